// ===== src/crc16acc_pkg.sv =====
`timescale 1ns / 1ps
// crc16acc_pkg: shared types, constants and the crc bit step for the
// crc-16/ccitt bit accumulator; no dependencies
package crc16acc_pkg;

	localparam int DATA_WIDTH = 64;
	localparam int DIGIT_W    = 8;
	localparam int NUM_DIGITS = DATA_WIDTH / DIGIT_W;
	localparam int DIG_IDX_W  = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
	localparam int DIG_BIT_W  = $clog2(DIGIT_W);
	localparam int CNT_W      = 7;
	localparam int CRC_W      = 16;
	localparam int AUG_BITS   = 16;
	localparam int AUG_DIGITS = AUG_BITS / DIGIT_W;

	localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
	localparam logic [CRC_W-1:0] CRC_SEED = 16'hFFFF;

	localparam int IN_TDATA_W  = 80;
	localparam int OUT_TDATA_W = 24;

	typedef enum logic [2:0] {
		OP_START  = 3'd0,
		OP_ACCUM  = 3'd1,
		OP_STOP   = 3'd2,
		OP_PAUSE  = 3'd3,
		OP_RESUME = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		MODE_STOPPED = 2'd0,
		MODE_STARTED = 2'd1,
		MODE_PAUSED  = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_SHIFT = 2'd1,
		ST_EMIT  = 2'd2
	} state_t;

	// one augmented crc step: message bit enters at bit 0
	function automatic logic [CRC_W-1:0] crc_bit_step(input logic [CRC_W-1:0] crc,
		input logic din);
		logic [CRC_W-1:0] r;
		r = {crc[CRC_W-2:0], din};
		if (crc[CRC_W-1]) begin
			r = r ^ CRC_POLY;
		end
		return r;
	endfunction

endpackage

// ===== src/crc16_ccitt_bit_accumulator_top.sv =====
`timescale 1ns / 1ps
// crc16_ccitt_bit_accumulator_top: command-driven crc-16/ccitt accumulator
// depends on crc16acc_pkg
//
// Each input transaction carries an opcode (start, accumulate, stop, pause,
// resume), up to 64 data bits and a bit count, and yields one output
// transaction with ok, the crc register, the run state and an in-use flag.
// Accumulate shifts the low bit_count bits in, msb first, into an augmented
// crc with polynomial 0x1021; stop appends 16 zero bits when started. The
// crc unit handles one 8-bit digit per cycle. Every transaction passes the
// accept cycle, then the shift steps if it runs (8 digits for an accumulate,
// 2 for a stop from the started state), then the load of the output register.
// One transaction is in work at a time; a new one is taken while the previous
// result waits on m_tready, and the load waits until that result has left.
module crc16_ccitt_bit_accumulator_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// opcode[2:0], data_bits[66:3], bit_count[73:67], zero fill
	input  logic [crc16acc_pkg::IN_TDATA_W-1:0]   s_tdata,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// ok[0], crc_value[16:1], run_state[18:17], in_use[19], zero fill
	output logic [crc16acc_pkg::OUT_TDATA_W-1:0]  m_tdata
);

	localparam int DW  = crc16acc_pkg::DATA_WIDTH;
	localparam int DGW = crc16acc_pkg::DIGIT_W;
	localparam int DIW = crc16acc_pkg::DIG_IDX_W;
	localparam int DBW = crc16acc_pkg::DIG_BIT_W;
	localparam int CW  = crc16acc_pkg::CNT_W;
	localparam int RW  = crc16acc_pkg::CRC_W;

	crc16acc_pkg::state_t state_q, state_d;
	crc16acc_pkg::mode_t  mode_q;
	crc16acc_pkg::op_t    op;

	logic [RW-1:0]  crc_q, crc_n;
	logic [DW-1:0]  sr_q;
	logic [CW-1:0]  cnt_q, cnt_in;
	logic [DIW-1:0] dig_q;
	logic           ok_q;
	logic           in_acc, out_load, last_dig;
	logic [DW-1:0]  data_in;
	logic [CW-1:0]  bc_in;

	assign op      = crc16acc_pkg::op_t'(s_tdata[2:0]);
	assign data_in = s_tdata[DW+2:3];
	assign bc_in   = s_tdata[DW+CW+2:DW+3];
	assign cnt_in  = (bc_in > CW'(DW)) ? CW'(DW) : bc_in;

	assign s_tready = (state_q == crc16acc_pkg::ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign last_dig = (dig_q == '0);

	// one digit of the crc, msb of the digit first, bits beyond the count skipped
	always_comb begin
		logic [DW-1:0] pos;
		crc_n = crc_q;
		for (int j = 0; j < DGW; j++) begin
			pos = DW'({dig_q, DBW'(DGW - 1 - j)});
			if (pos < DW'(cnt_q)) begin
				crc_n = crc16acc_pkg::crc_bit_step(crc_n, sr_q[DW-1-j]);
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		out_load = 1'b0;
		case (state_q)
			crc16acc_pkg::ST_IDLE: begin
				if (in_acc) begin
					if ((op == crc16acc_pkg::OP_ACCUM || op == crc16acc_pkg::OP_STOP) &&
						mode_q == crc16acc_pkg::MODE_STARTED) begin
						state_d = crc16acc_pkg::ST_SHIFT;
					end else begin
						state_d = crc16acc_pkg::ST_EMIT;
					end
				end
			end
			crc16acc_pkg::ST_SHIFT: begin
				if (last_dig) begin
					state_d = crc16acc_pkg::ST_EMIT;
				end
			end
			crc16acc_pkg::ST_EMIT: begin
				if (!m_tvalid || m_tready) begin
					out_load = 1'b1;
					state_d  = crc16acc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = crc16acc_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= crc16acc_pkg::ST_IDLE;
			mode_q   <= crc16acc_pkg::MODE_STOPPED;
			crc_q    <= '0;
			ok_q     <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				ok_q <= 1'b0;
				case (op)
					crc16acc_pkg::OP_START: begin
						crc_q  <= crc16acc_pkg::CRC_SEED;
						mode_q <= crc16acc_pkg::MODE_STARTED;
						ok_q   <= 1'b1;
					end
					crc16acc_pkg::OP_ACCUM: begin
						ok_q <= (mode_q != crc16acc_pkg::MODE_STOPPED);
					end
					crc16acc_pkg::OP_STOP: begin
						mode_q <= crc16acc_pkg::MODE_STOPPED;
						ok_q   <= 1'b1;
					end
					crc16acc_pkg::OP_PAUSE: begin
						if (mode_q != crc16acc_pkg::MODE_STOPPED) begin
							mode_q <= crc16acc_pkg::MODE_PAUSED;
							ok_q   <= 1'b1;
						end
					end
					crc16acc_pkg::OP_RESUME: begin
						if (mode_q == crc16acc_pkg::MODE_PAUSED) begin
							mode_q <= crc16acc_pkg::MODE_STARTED;
							ok_q   <= 1'b1;
						end
					end
					default: begin
						ok_q <= 1'b0;
					end
				endcase
			end else if (state_q == crc16acc_pkg::ST_SHIFT) begin
				crc_q <= crc_n;
			end
			if (out_load) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	// digit shift register, counters and the output data register
	always_ff @(posedge clk) begin
		if (in_acc) begin
			if (op == crc16acc_pkg::OP_STOP) begin
				sr_q  <= '0;
				cnt_q <= CW'(crc16acc_pkg::AUG_BITS);
				dig_q <= DIW'(crc16acc_pkg::AUG_DIGITS - 1);
			end else begin
				sr_q  <= data_in;
				cnt_q <= cnt_in;
				dig_q <= DIW'(crc16acc_pkg::NUM_DIGITS - 1);
			end
		end else if (state_q == crc16acc_pkg::ST_SHIFT) begin
			sr_q  <= sr_q << DGW;
			dig_q <= dig_q - DIW'(1);
		end
		if (out_load) begin
			m_tdata <= {4'd0, (mode_q != crc16acc_pkg::MODE_STOPPED), mode_q, crc_q, ok_q};
		end
	end

endmodule
